[rtl/core/ibt_pkg.sv]
// ----------------------------------------------------------------------------
// ibt_pkg
// Types and constants shared by the interval booking table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ibt_pkg;

    localparam int CAPACITY = 1024;
    localparam int TIME_W   = 30;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SLOT_W   = 2 * TIME_W;

    localparam logic [1:0] ST_BOOKED  = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
    } t_req;

    typedef struct packed {
        logic       accepted;
        logic [1:0] status;
    } t_resp;

endpackage

`default_nettype wire

[rtl/core/interval_booking_table_unit.sv]
// Flow: a well-formed request goes through S_SCAN, which reads one stored
//   interval per cycle from the slot RAM, and then S_RESP, which loads the
//   result word; an empty or reversed one goes straight to S_RESP. Requests
//   are taken one at a time: o_in_stall is high until the unit is idle again.
// Reset: synchronous, active low; clears the booked count and the control
//   state. Slot RAM contents are not cleared and are read only once written.
// ----------------------------------------------------------------------------
// interval_booking_table_unit
// Books half-open intervals that overlap no stored one, appending to a RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module interval_booking_table_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ibt_pkg::t_req i_in_word,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ibt_pkg::t_resp     o_out_word
);

    import ibt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0]        r_state, n_state;
    t_req              r_req;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_rd_pend, n_rd_pend;
    logic              r_hit, n_hit;
    logic [1:0]        r_status, n_status;
    logic              r_out_valid, n_out_valid;
    t_resp             r_out_word, n_out_word;

    logic              in_acc;
    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] rd_data;
    logic [TIME_W-1:0] slot_start;
    logic [TIME_W-1:0] slot_end;
    logic              slot_hit;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign rd_en      = (r_state == S_SCAN) && (r_idx < r_count);
    assign slot_start = rd_data[SLOT_W-1:TIME_W];
    assign slot_end   = rd_data[TIME_W-1:0];
    assign slot_hit   = (r_req.start_time < slot_end) && (slot_start < r_req.end_time);

    ibt_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(CAPACITY)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_count[ADDR_W-1:0]),
        .i_wdata({r_req.start_time, r_req.end_time}),
        .i_re   (rd_en),
        .i_raddr(r_idx[ADDR_W-1:0]),
        .o_rdata(rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rd_pend   = 1'b0;
        n_hit       = r_hit;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        wr_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx = '0;
                    n_hit = 1'b0;
                    if (i_in_word.end_time <= i_in_word.start_time) begin
                        n_status = ST_INVALID;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // fold in the word read last cycle
                if (r_rd_pend && slot_hit) begin
                    n_hit = 1'b1;
                end
                if (rd_en) begin
                    n_idx     = r_idx + CNT_W'(1);
                    n_rd_pend = 1'b1;
                end else if (!r_rd_pend) begin
                    n_state = S_RESP;
                    if (r_hit) begin
                        n_status = ST_OVERLAP;
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_BOOKED;
                        wr_en    = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
            end
            S_RESP: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out_word.status   = r_status;
                    n_out_word.accepted = (r_status == ST_BOOKED);
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in_word;
        end
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_status   <= n_status;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

[rtl/core/ibt_ram.sv]
// ----------------------------------------------------------------------------
// ibt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/ibt_checker.sv]
// ----------------------------------------------------------------------------
// ibt_checker
// Port-level checks for the interval booking table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibt_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire ibt_pkg::t_req  i_in_word,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire ibt_pkg::t_resp o_out_word
);

    import ibt_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_acc_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.accepted == (o_out_word.status == ST_BOOKED)))
        else $error("accepted flag disagrees with status");

    // one request at a time: stall right after a word is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs active after reset");

endmodule

bind interval_booking_table_unit ibt_checker u_ibt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_word  (i_in_word),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_word (o_out_word)
);

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for interval_booking_table_unit. Drives booking requests
// through the valid/stall input channel, predicts each response word from its
// own copy of the interval table, and compares every returned word in order.
// Covers empty/reversed intervals, overlaps, edge touching at both range ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ibt_pkg::*;

    localparam longint unsigned TIME_MAX     = (64'd1 << TIME_W) - 1;
    localparam longint unsigned WINDOW       = 64'd1 << 20;
    localparam longint unsigned FILL_BASE    = 64'h3000_0000;
    localparam int              RANDOM_ITEMS = 540;
    localparam int              TAIL_ITEMS   = 20;
    localparam int              MAX_ITEMS    = 2000;
    localparam int              CYCLE_LIMIT  = MAX_ITEMS * (CAPACITY + 64) * 4;
    localparam int              HOLD_START   = 5000;
    localparam int              HOLD_CYCLES  = 3000;
    localparam int              CALM_START   = 10000;
    localparam int              CALM_END     = 25000;

    // Tracks the booked intervals and the response words still owed.
    class booking_scoreboard;
        logic [TIME_W-1:0] slot_lo [CAPACITY];
        logic [TIME_W-1:0] slot_hi [CAPACITY];
        int unsigned       booked;
        t_resp             owed_q[$];
        int unsigned       mismatches;
        int unsigned       status_seen [4];

        function new();
            booked     = 0;
            mismatches = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function t_resp predict_booking(t_req r);
            t_resp res;
            bit    hit;
            hit = 1'b0;
            if (r.end_time <= r.start_time) begin
                res.status = ST_INVALID;
            end else begin
                for (int i = 0; i < booked; i++) begin
                    if (r.start_time < slot_hi[i] && slot_lo[i] < r.end_time)
                        hit = 1'b1;
                end
                if (hit) begin
                    res.status = ST_OVERLAP;
                end else if (booked >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    slot_lo[booked] = r.start_time;
                    slot_hi[booked] = r.end_time;
                    booked++;
                    res.status = ST_BOOKED;
                end
            end
            res.accepted = (res.status == ST_BOOKED);
            return res;
        endfunction

        function void note_request(t_req r);
            owed_q.push_back(predict_booking(r));
        endfunction

        function void check_response(t_resp got);
            t_resp want;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected response word accepted=%b status=%0d",
                             $realtime, got.accepted, got.status);
                return;
            end
            want = owed_q.pop_front();
            status_seen[want.status]++;
            if (got.accepted !== want.accepted || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch: expected accepted=%b status=%0d,",
                              " got accepted=%b status=%0d"},
                             $realtime, want.accepted, want.status,
                             got.accepted, got.status);
            end
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_stall;
    t_req  i_in_word;
    logic  o_out_valid;
    logic  i_out_stall;
    t_resp o_out_word;

    booking_scoreboard sb = new();
    bit                in_calm;
    int                cycle_count = 0;
    int                hold_left = 0;

    interval_booking_table_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: check accepted words, then pick the next stall value.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, sb.owed_q.size());
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_response(o_out_word);
        if (cycle_count == HOLD_START)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (cycle_count > CALM_START && cycle_count < CALM_END) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 11);
        end
    end

    function automatic t_req span(longint unsigned s, longint unsigned e);
        t_req r;
        if (e > TIME_MAX) e = TIME_MAX;
        r.start_time = s[TIME_W-1:0];
        r.end_time   = e[TIME_W-1:0];
        return r;
    endfunction

    // Mostly requests near stored intervals or in a dense window, plus noise.
    function automatic t_req make_request();
        int unsigned     roll;
        int unsigned     idx;
        longint unsigned len;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned p;
        longint unsigned s;
        longint unsigned e;
        roll = $urandom_range(0, 99);
        len  = $urandom_range(1, 64);
        if (roll < 10) begin
            s = $urandom & TIME_MAX;
            e = $urandom_range(0, int'(s));
        end else if (roll < 45 && sb.booked > 0) begin
            idx = $urandom_range(0, sb.booked - 1);
            lo  = sb.slot_lo[idx];
            hi  = sb.slot_hi[idx];
            case ($urandom_range(0, 3))
                0: begin
                    s = (lo > len) ? lo - len : 0;
                    e = lo;
                end
                1: begin
                    s = hi;
                    e = hi + len;
                end
                default: begin
                    p = lo + $urandom_range(0, int'(hi - lo - 1));
                    s = (p > len) ? p - $urandom_range(0, int'(len)) : 0;
                    e = p + 1 + $urandom_range(0, 64);
                end
            endcase
        end else if (roll < 55) begin
            s = $urandom & TIME_MAX;
            e = s + 1 + $urandom_range(0, 255);
        end else if (roll < 57) begin
            // keep wide intervals clear of the upper region
            s = $urandom_range(0, int'(FILL_BASE - 2));
            e = $urandom_range(int'(s + 1), int'(FILL_BASE - 1));
        end else begin
            s = $urandom_range(0, int'(WINDOW - 1));
            e = s + 1 + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 4095));
        end
        return span(s, e);
    endfunction

    task automatic send_request(t_req w);
        int gap;
        gap = 0;
        if (!in_calm && $urandom_range(0, 99) < 11)
            gap = $urandom_range(1, 40);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(w);
    endtask

    initial begin
        in_calm     = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_out_stall <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty and reversed intervals
        send_request(span(5, 5));
        send_request(span(0, 0));
        send_request(span(TIME_MAX, TIME_MAX));
        send_request(span(TIME_MAX, 0));
        send_request(span(100, 99));
        // bookings at both ends, touching edges, overlaps
        send_request(span(0, 1));
        send_request(span(1, 2));
        send_request(span(0, 2));
        send_request(span(TIME_MAX - 1, TIME_MAX));
        send_request(span(TIME_MAX - 2, TIME_MAX - 1));
        send_request(span(0, TIME_MAX));
        send_request(span(64'h2AAA_AAAA, 64'h2AAA_AAAB));
        send_request(span(64'h2AAA_AAA9, 64'h2AAA_AAAC));
        send_request(span(64'h1555_5555, 64'h1555_5556));
        send_request(span(64'h1555_5554, 64'h1555_5556));
        send_request(span(64'h1555_5555, 64'h1555_5556));
        send_request(span(64'h1555_5556, 64'h1555_5560));
        send_request(span(64'h1FFF_FFFF, 64'h2000_0000));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            in_calm = (n >= 150 && n < 300);
            send_request(make_request());
        end
        in_calm = 1'b0;

        // late overlap and reversed requests, then a random mix
        send_request(span(0, 2));
        send_request(span(7, 3));
        repeat (TAIL_ITEMS) send_request(make_request());
        i_in_valid <= 1'b0;

        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 16) @(posedge i_clk);

        $display({"checked %0d response words: %0d booked, %0d overlap,",
                  " %0d full, %0d empty/reversed"},
                 sb.status_seen[ST_BOOKED] + sb.status_seen[ST_OVERLAP] +
                 sb.status_seen[ST_FULL] + sb.status_seen[ST_INVALID],
                 sb.status_seen[ST_BOOKED], sb.status_seen[ST_OVERLAP],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_INVALID]);
        $display("table reached %0d of %0d slots, %0d mismatches in %0d cycles",
                 sb.booked, CAPACITY, sb.mismatches, cycle_count);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
